### design/cbm_pkg.sv
// Shared types, constants and command structs for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    // Field widths
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int OP_W       = 2;
    localparam int PAGE_W     = 11;
    localparam int OFFSET_W   = 13;
    localparam int PRG_W      = 9;
    localparam int CHR_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Remainder unit: one quotient bit per step
    localparam int DIVIDEND_W = 12;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_PAGES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_PAGES  = 2'd2;

    // Board modes
    localparam logic BOARD_LATCH = 1'b0;
    localparam logic BOARD_REGS  = 1'b1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WR_HIGH = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_LOW  = 2'd1;
    localparam logic [OP_W-1:0] OP_CPU_RD  = 2'd2;
    localparam logic [OP_W-1:0] OP_PPU_RD  = 2'd3;

    // Addresses and masks
    localparam logic [ADDR_W-1:0] ADDR_PRG_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] REG_PRG       = 16'h7ffd;
    localparam logic [ADDR_W-1:0] REG_CHR_LOW   = 16'h7ffe;
    localparam logic [ADDR_W-1:0] REG_CHR_HIGH  = 16'h7fff;
    localparam logic [DATA_W-1:0] MASK_PRG_BIT  = 8'h01;
    localparam logic [DATA_W-1:0] MASK_CHR      = 8'h0f;

    // Page counts and reset values
    localparam logic [CHR_W-1:0] CHR_RAM_PAGES   = 11'd8;
    localparam logic [PRG_W-1:0] PRG_RESET_PAGES = 9'd4;
    localparam logic [CHR_W-1:0] CHR_RESET_PAGES = 11'd8;
    localparam logic [CHR_W-1:0] CHR_HIGH_RESET  = 11'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        K_IGNORE,
        K_PRG_WR,
        K_CHR_LOW,
        K_CHR_HIGH,
        K_CPU_ZERO,
        K_CPU_READ,
        K_PPU_READ
    } kind_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

### design/cbm_if.sv
// Valid/ready channel interfaces for access items and result items.
`default_nettype none

interface cbm_access_if;
    logic                          valid;
    logic                          ready;
    logic [cbm_pkg::OP_W-1:0]      op;
    logic [cbm_pkg::ADDR_W-1:0]    addr;
    logic [cbm_pkg::DATA_W-1:0]    data;
    logic [cbm_pkg::DATA_W-1:0]    bus_byte;

    modport source (output valid, output op, output addr, output data, output bus_byte,
                    input ready);
    modport sink   (input valid, input op, input addr, input data, input bus_byte,
                    output ready);
endinterface

interface cbm_result_if;
    logic                          valid;
    logic                          ready;
    logic [cbm_pkg::PAGE_W-1:0]    page;
    logic [cbm_pkg::OFFSET_W-1:0]  offset;
    logic                          from_chr_ram;
    logic                          ignored;

    modport source (output valid, output page, output offset, output from_chr_ram,
                    output ignored, input ready);
    modport sink   (input valid, input page, input offset, input from_chr_ram,
                    input ignored, output ready);
endinterface

`default_nettype wire

### design/cbm_ctrl.sv
// Controller state machine: accept, step the remainder unit, commit the result.
`default_nettype none

module cbm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cbm_pkg::cmd_t         cmd,
    input  wire cbm_pkg::status_t status
);

    cbm_pkg::state_t state_reg;
    cbm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cbm_pkg::ST_DIV;
                end
            end
            cbm_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = cbm_pkg::ST_DONE;
                end
            end
            cbm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = cbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            cbm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cbm_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            cbm_pkg::ST_DONE:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Hold the result until taken; a commit refills the output register
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == cbm_pkg::ST_DIV))
        else $error("accepted item did not start the remainder unit");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result valid rose without a commit");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbm_pkg::ST_DIV && status.div_last) |=>
        (state_reg == cbm_pkg::ST_DONE))
        else $error("last remainder step did not reach commit");

endmodule

`default_nettype wire

### design/cbm_dp.sv
// Datapath: configuration, bank state, bit-serial remainder unit, output register.
`default_nettype none

module cbm_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [cbm_pkg::OP_W-1:0]         op,
    input  wire logic [cbm_pkg::ADDR_W-1:0]       addr,
    input  wire logic [cbm_pkg::DATA_W-1:0]       data,
    input  wire logic [cbm_pkg::DATA_W-1:0]       bus_byte,
    input  wire cbm_pkg::cmd_t                    cmd,
    output cbm_pkg::status_t                      status,
    output logic [cbm_pkg::PAGE_W-1:0]            page,
    output logic [cbm_pkg::OFFSET_W-1:0]          offset,
    output logic                                  from_chr_ram,
    output logic                                  ignored
);

    // Configuration
    logic                         board_mode_reg, board_mode_next;
    logic [cbm_pkg::PRG_W-1:0]    prg_pages_reg, prg_pages_next;
    logic [cbm_pkg::CHR_W-1:0]    chr_pages_reg, chr_pages_next;
    logic [cbm_pkg::CHR_W-1:0]    chr_count;

    // Bank state
    logic [cbm_pkg::PRG_W-1:0]    prg_base_reg, prg_base_next;
    logic [cbm_pkg::CHR_W-1:0]    chr_low_reg, chr_low_next;
    logic [cbm_pkg::CHR_W-1:0]    chr_high_reg, chr_high_next;

    // Item under work
    cbm_pkg::kind_t                   kind_reg, kind_next, kind_load;
    logic [cbm_pkg::DIVIDEND_W-1:0]   dividend_reg, dividend_next, dividend_load;
    logic [cbm_pkg::CHR_W-1:0]        divisor_reg, divisor_next, divisor_load;
    logic [cbm_pkg::CHR_W-1:0]        rem_reg, rem_next, rem_step;
    logic [cbm_pkg::STEP_W-1:0]       step_cnt_reg, step_cnt_next;
    logic [cbm_pkg::OFFSET_W-1:0]     off_reg, off_next, off_load;
    logic                             ram_reg, ram_next, ram_load;

    // Output register
    logic [cbm_pkg::PAGE_W-1:0]       page_reg, page_next;
    logic [cbm_pkg::OFFSET_W-1:0]     offset_reg, offset_next;
    logic                             from_ram_reg, from_ram_next;
    logic                             ignored_reg, ignored_next;

    logic [cbm_pkg::DATA_W-1:0]       latch_bank;
    logic [cbm_pkg::CHR_W-1:0]        ppu_base;
    logic [cbm_pkg::DIVIDEND_W-1:0]   trial;
    logic [cbm_pkg::DIVIDEND_W-1:0]   diff;
    logic                             fits;

    assign chr_count  = (chr_pages_reg == '0) ? cbm_pkg::CHR_RAM_PAGES : chr_pages_reg;
    assign latch_bank = data & bus_byte;
    assign ppu_base   = addr[12] ? chr_high_reg : chr_low_reg;

    always_comb
    begin
        board_mode_next = board_mode_reg;
        prg_pages_next  = prg_pages_reg;
        chr_pages_next  = chr_pages_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cbm_pkg::CFG_BOARD_MODE: board_mode_next = cfg_data[0];
                cbm_pkg::CFG_PRG_PAGES:  prg_pages_next  = cfg_data[cbm_pkg::PRG_W-1:0];
                cbm_pkg::CFG_CHR_PAGES:  chr_pages_next  = cfg_data[cbm_pkg::CHR_W-1:0];
                default:                 board_mode_next = board_mode_reg;
            endcase
        end
    end

    // Classify the item and pick dividend and divisor
    always_comb
    begin
        kind_load     = cbm_pkg::K_IGNORE;
        dividend_load = '0;
        divisor_load  = chr_count;
        off_load      = '0;
        ram_load      = 1'b0;
        case (op)
            cbm_pkg::OP_WR_HIGH:
            begin
                if (board_mode_reg == cbm_pkg::BOARD_LATCH
                    && addr >= cbm_pkg::ADDR_PRG_BASE && prg_pages_reg != '0)
                begin
                    kind_load     = cbm_pkg::K_PRG_WR;
                    dividend_load = {2'b00, latch_bank, 2'b00};
                    divisor_load  = {2'b00, prg_pages_reg};
                end
            end
            cbm_pkg::OP_WR_LOW:
            begin
                if (board_mode_reg == cbm_pkg::BOARD_REGS)
                begin
                    if (addr == cbm_pkg::REG_PRG)
                    begin
                        if (prg_pages_reg != '0)
                        begin
                            kind_load     = cbm_pkg::K_PRG_WR;
                            dividend_load = {2'b00, data & cbm_pkg::MASK_PRG_BIT, 2'b00};
                            divisor_load  = {2'b00, prg_pages_reg};
                        end
                    end
                    else if (addr == cbm_pkg::REG_CHR_LOW)
                    begin
                        kind_load     = cbm_pkg::K_CHR_LOW;
                        dividend_load = {2'b00, data & cbm_pkg::MASK_CHR, 2'b00};
                    end
                    else if (addr == cbm_pkg::REG_CHR_HIGH)
                    begin
                        kind_load     = cbm_pkg::K_CHR_HIGH;
                        dividend_load = {2'b00, data & cbm_pkg::MASK_CHR, 2'b00};
                    end
                end
            end
            cbm_pkg::OP_CPU_RD:
            begin
                if (addr < cbm_pkg::ADDR_PRG_BASE)
                begin
                    kind_load = cbm_pkg::K_CPU_ZERO;
                end
                else
                begin
                    kind_load     = cbm_pkg::K_CPU_READ;
                    dividend_load = {3'b000, prg_base_reg} + {10'b0, addr[14:13]};
                    divisor_load  = {2'b00, prg_pages_reg};
                    off_load      = addr[cbm_pkg::OFFSET_W-1:0];
                end
            end
            cbm_pkg::OP_PPU_RD:
            begin
                kind_load     = cbm_pkg::K_PPU_READ;
                dividend_load = {1'b0, ppu_base} + {10'b0, addr[11:10]};
                off_load      = {3'b000, addr[9:0]};
                ram_load      = (chr_pages_reg == '0);
            end
            default:
            begin
                kind_load = cbm_pkg::K_IGNORE;
            end
        endcase
    end

    // Restoring remainder step: shift in one dividend bit, subtract if it fits
    assign trial    = {rem_reg, dividend_reg[cbm_pkg::DIVIDEND_W-1]};
    assign fits     = trial >= {1'b0, divisor_reg};
    assign diff     = trial - {1'b0, divisor_reg};
    assign rem_step = fits ? diff[cbm_pkg::CHR_W-1:0] : trial[cbm_pkg::CHR_W-1:0];

    assign status.div_last = (step_cnt_reg == cbm_pkg::STEP_W'(cbm_pkg::DIV_STEPS - 1));

    always_comb
    begin
        kind_next     = kind_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        step_cnt_next = step_cnt_reg;
        off_next      = off_reg;
        ram_next      = ram_reg;
        if (cmd.load)
        begin
            kind_next     = kind_load;
            dividend_next = dividend_load;
            divisor_next  = divisor_load;
            rem_next      = '0;
            step_cnt_next = '0;
            off_next      = off_load;
            ram_next      = ram_load;
        end
        else if (cmd.step)
        begin
            dividend_next = {dividend_reg[cbm_pkg::DIVIDEND_W-2:0], 1'b0};
            rem_next      = rem_step;
            step_cnt_next = step_cnt_reg + 1'b1;
        end
    end

    // Build the result and update bank state on commit
    always_comb
    begin
        page_next     = page_reg;
        offset_next   = offset_reg;
        from_ram_next = from_ram_reg;
        ignored_next  = ignored_reg;
        prg_base_next = prg_base_reg;
        chr_low_next  = chr_low_reg;
        chr_high_next = chr_high_reg;
        if (cmd.commit)
        begin
            page_next     = '0;
            offset_next   = '0;
            from_ram_next = 1'b0;
            ignored_next  = 1'b0;
            case (kind_reg)
                cbm_pkg::K_IGNORE:
                begin
                    ignored_next = 1'b1;
                end
                cbm_pkg::K_PRG_WR:
                begin
                    page_next     = rem_reg;
                    prg_base_next = rem_reg[cbm_pkg::PRG_W-1:0];
                end
                cbm_pkg::K_CHR_LOW:
                begin
                    page_next    = rem_reg;
                    chr_low_next = rem_reg;
                end
                cbm_pkg::K_CHR_HIGH:
                begin
                    page_next     = rem_reg;
                    chr_high_next = rem_reg;
                end
                cbm_pkg::K_CPU_ZERO:
                begin
                    page_next = '0;
                end
                cbm_pkg::K_CPU_READ:
                begin
                    // no program ROM: page stays zero
                    page_next   = (divisor_reg == '0) ? '0 : rem_reg;
                    offset_next = off_reg;
                end
                cbm_pkg::K_PPU_READ:
                begin
                    page_next     = rem_reg;
                    offset_next   = off_reg;
                    from_ram_next = ram_reg;
                end
                default:
                begin
                    ignored_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_mode_reg <= cbm_pkg::BOARD_LATCH;
            prg_pages_reg  <= cbm_pkg::PRG_RESET_PAGES;
            chr_pages_reg  <= cbm_pkg::CHR_RESET_PAGES;
            prg_base_reg   <= '0;
            chr_low_reg    <= '0;
            chr_high_reg   <= cbm_pkg::CHR_HIGH_RESET;
            step_cnt_reg   <= '0;
        end
        else
        begin
            board_mode_reg <= board_mode_next;
            prg_pages_reg  <= prg_pages_next;
            chr_pages_reg  <= chr_pages_next;
            prg_base_reg   <= prg_base_next;
            chr_low_reg    <= chr_low_next;
            chr_high_reg   <= chr_high_next;
            step_cnt_reg   <= step_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        off_reg      <= off_next;
        ram_reg      <= ram_next;
        page_reg     <= page_next;
        offset_reg   <= offset_next;
        from_ram_reg <= from_ram_next;
        ignored_reg  <= ignored_next;
    end

    assign page         = page_reg;
    assign offset       = offset_reg;
    assign from_chr_ram = from_ram_reg;
    assign ignored      = ignored_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (divisor_reg == '0 || rem_reg < divisor_reg))
        else $error("partial remainder not below divisor");

    a_prg_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && kind_reg == cbm_pkg::K_PRG_WR) |=> (prg_base_reg < prg_pages_reg))
        else $error("program base outside program ROM");

    a_ppu_page_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && kind_reg == cbm_pkg::K_PPU_READ) |=> (page_reg < chr_count))
        else $error("pattern page outside pattern memory");

endmodule

`default_nettype wire

### design/cartridge_bank_mapper_bus_conflict.sv
// Top level of the cartridge bank mapper: controller plus datapath.
//
//  channel   dir  handshake          payload
//  access    in   valid/ready        op[1:0] addr[15:0] data[7:0] bus_byte[7:0]
//  result    out  valid/ready        page[10:0] offset[12:0] from_chr_ram ignored
//  cfg       in   cfg_we (no wait)   cfg_index[1:0] cfg_data[10:0]
//
// On the way from accept to result valid, the accepting edge loads the operands,
// twelve steps of the bit-serial remainder unit follow (one bit per cycle), then one
// commit into the output register. A new item is accepted in the cycle after commit,
// even while the result still waits; a stalled result delays only the commit of the
// following item. Reset is asynchronous; the control, configuration and bank
// registers load their reset values at once.
`default_nettype none

module cartridge_bank_mapper_bus_conflict (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [cbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    cbm_access_if.sink                           access,
    cbm_result_if.source                         result
);

    cbm_pkg::cmd_t    cmd;
    cbm_pkg::status_t status;

    cbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (access.valid),
        .in_ready  (access.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    cbm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (access.op),
        .addr         (access.addr),
        .data         (access.data),
        .bus_byte     (access.bus_byte),
        .cmd          (cmd),
        .status       (status),
        .page         (result.page),
        .offset       (result.offset),
        .from_chr_ram (result.from_chr_ram),
        .ignored      (result.ignored)
    );

endmodule

`default_nettype wire
